/* sv/cwds_pkg.sv */
// Shared types and constants of the checkpoint watchdog supervisor.
`timescale 1ns / 1ps

package cwds_pkg;

    // Number of supervised checkpoints: control, sensors, comms
    localparam int NUM_CP = 3;

    // Event modes carried in tuser
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_REPORT  = 2'd1;
    localparam logic [1:0] MODE_SERVICE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_BUDGET_CONTROL  = 3'd0;
    localparam logic [2:0] CFG_BUDGET_SENSORS  = 3'd1;
    localparam logic [2:0] CFG_BUDGET_COMMS    = 3'd2;
    localparam logic [2:0] CFG_MIN_REFRESH_GAP = 3'd3;
    localparam logic [2:0] CFG_HEALTHY_RUNTIME = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_BUDGET_CONTROL  = 16'd30;
    localparam logic [15:0] RST_BUDGET_SENSORS  = 16'd30;
    localparam logic [15:0] RST_BUDGET_COMMS    = 16'd60;
    localparam logic [15:0] RST_MIN_REFRESH_GAP = 16'd8;
    localparam logic [31:0] RST_HEALTHY_RUNTIME = 32'd60000;

    // One input event
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [1:0]  checkpoint;
        logic        limp_in;
    } t_item;

    // Configuration register set
    typedef struct packed {
        logic [NUM_CP-1:0][15:0] budget;
        logic [15:0]             min_refresh_gap;
        logic [31:0]             healthy_runtime;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic              refresh;
        logic [NUM_CP-1:0] starved_mask;
        logic [31:0]       refresh_count;
        logic [31:0]       starve_count;
        logic              clear_streaks;
        logic              limp;
        logic              safe_state_request;
    } t_result;

endpackage

/* sv/cwds_core.sv */
// Supervisor state and the per-event decision logic.
`timescale 1ns / 1ps

module cwds_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  cwds_pkg::t_item  i_item,
    input  cwds_pkg::t_cfg   i_cfg,
    output cwds_pkg::t_result o_res
);

    logic [cwds_pkg::NUM_CP-1:0][31:0] r_report_time, n_report_time;
    logic [cwds_pkg::NUM_CP-1:0]       r_reported, n_reported;
    logic [31:0]                       r_last_refresh, n_last_refresh;
    logic [cwds_pkg::NUM_CP-1:0]       r_stale_bits, n_stale_bits;
    logic [31:0]                       r_refreshes, n_refreshes;
    logic [31:0]                       r_starves, n_starves;
    logic                              r_limp, n_limp;
    logic                              r_streaks_done, n_streaks_done;
    logic                              r_running, n_running;

    logic [cwds_pkg::NUM_CP-1:0] stale;
    logic [31:0]                 age;
    logic [31:0]                 gap_age;
    logic                        refresh;
    logic                        clear;
    logic                        safe;

    // Staleness check per checkpoint: never reported, or age over budget
    always_comb begin
        stale = '0;
        age   = '0;
        for (int i = 0; i < cwds_pkg::NUM_CP; i++) begin
            age = i_item.now_ms - r_report_time[i];
            stale[i] = !r_reported[i] || (age > {16'd0, i_cfg.budget[i]});
        end
    end

    assign gap_age = i_item.now_ms - r_last_refresh;

    // Next state for the event
    always_comb begin
        n_report_time  = r_report_time;
        n_reported     = r_reported;
        n_last_refresh = r_last_refresh;
        n_stale_bits   = r_stale_bits;
        n_refreshes    = r_refreshes;
        n_starves      = r_starves;
        n_limp         = r_limp;
        n_streaks_done = r_streaks_done;
        n_running      = r_running;
        refresh        = 1'b0;
        clear          = 1'b0;
        safe           = 1'b0;
        if (i_step) begin
            unique case (i_item.mode)
                cwds_pkg::MODE_START: begin
                    n_limp = i_item.limp_in;
                    safe   = i_item.limp_in;
                    for (int i = 0; i < cwds_pkg::NUM_CP; i++) begin
                        n_report_time[i] = i_item.now_ms;
                    end
                    n_reported     = '0;
                    n_last_refresh = i_item.now_ms;
                    n_stale_bits   = '0;
                    n_running      = 1'b1;
                end
                cwds_pkg::MODE_REPORT: begin
                    // index three matches no checkpoint and is dropped
                    for (int i = 0; i < cwds_pkg::NUM_CP; i++) begin
                        if (i_item.checkpoint == 2'(i)) begin
                            n_report_time[i] = i_item.now_ms;
                            n_reported[i]    = 1'b1;
                        end
                    end
                end
                cwds_pkg::MODE_SERVICE: begin
                    if (r_running) begin
                        n_stale_bits = stale;
                        if (stale != '0) begin
                            n_starves = r_starves + 32'd1;
                        end else if (gap_age >= {16'd0, i_cfg.min_refresh_gap}) begin
                            refresh        = 1'b1;
                            n_last_refresh = i_item.now_ms;
                            n_refreshes    = r_refreshes + 32'd1;
                            if (!r_streaks_done &&
                                i_item.now_ms >= i_cfg.healthy_runtime) begin
                                clear          = 1'b1;
                                n_streaks_done = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_time  <= '0;
            r_reported     <= '0;
            r_last_refresh <= '0;
            r_stale_bits   <= '0;
            r_refreshes    <= '0;
            r_starves      <= '0;
            r_limp         <= 1'b0;
            r_streaks_done <= 1'b0;
            r_running      <= 1'b0;
        end else begin
            r_report_time  <= n_report_time;
            r_reported     <= n_reported;
            r_last_refresh <= n_last_refresh;
            r_stale_bits   <= n_stale_bits;
            r_refreshes    <= n_refreshes;
            r_starves      <= n_starves;
            r_limp         <= n_limp;
            r_streaks_done <= n_streaks_done;
            r_running      <= n_running;
        end
    end

    // Result word shows the updated state plus this event's pulses
    assign o_res.refresh            = refresh;
    assign o_res.starved_mask       = n_stale_bits;
    assign o_res.refresh_count      = n_refreshes;
    assign o_res.starve_count       = n_starves;
    assign o_res.clear_streaks      = clear;
    assign o_res.limp               = n_limp;
    assign o_res.safe_state_request = safe;

`ifndef ASSERT_OFF
    a_refresh_healthy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        refresh |-> (n_stale_bits == '0))
        else $error("refresh issued with a stale checkpoint");
    a_refresh_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        refresh |=> (r_refreshes == $past(r_refreshes) + 32'd1))
        else $error("refresh counter did not advance on refresh");
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_streaks_done |-> !clear)
        else $error("second streak clear pulse");
    a_safe_limp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        safe |=> r_limp && r_running)
        else $error("safe state request without latched limp");
`endif

endmodule

/* sv/checkpoint_watchdog_supervisor_top.sv */
// Top level of the checkpoint watchdog supervisor: stream ports, registers, pipeline.
`timescale 1ns / 1ps

// Usage:
//   Slave stream (i_s_*) carries one event per word: tuser is the mode
//   (start, checkpoint report, service), tdata holds now_ms, the checkpoint
//   index and the limp flag. Master stream (o_m_*) returns exactly one result
//   word per event, in order.
//   Configuration port (i_cfg_*) writes the budgets, the minimum refresh gap
//   and the healthy runtime by register index; it is always ready and should
//   be written only while no event is in flight.
//   Path: an accepted word goes through the input register, then the
//   decision logic into the result register.
//   Throughput: one word per cycle while i_m_tready stays high; the decision
//   is a single pass of three subtract-and-compare checks plus counter increments.
//   Receiver stall: the result register holds, the input register fills, and
//   then tready drops; no word is lost or repeated.
//   Reset (i_rst_n low, synchronous): pipeline empty, all supervisor state
//   cleared, configuration registers back to their default values.
module checkpoint_watchdog_supervisor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [31:0] now_ms, [33:32] checkpoint, [34] limp_in
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [0] refresh, [3:1] starved_mask,
                                     // [35:4] refresh_count, [67:36] starve_count,
                                     // [68] clear_streaks, [69] limp,
                                     // [70] safe_state_request
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic              r_s1_valid;
    cwds_pkg::t_item   r_s1_item;
    logic              r_out_valid;
    cwds_pkg::t_result r_res;
    cwds_pkg::t_result core_res;
    cwds_pkg::t_cfg    r_cfg;

    logic in_accept;
    logic s2_free;
    logic s1_move;

    // Pipeline flow control
    assign s2_free    = !r_out_valid || i_m_tready;
    assign s1_move    = r_s1_valid && s2_free;
    assign o_s_tready = !r_s1_valid || s2_free;
    assign in_accept  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item.mode       <= i_s_tuser;
            r_s1_item.now_ms     <= i_s_tdata[31:0];
            r_s1_item.checkpoint <= i_s_tdata[33:32];
            r_s1_item.limp_in    <= i_s_tdata[34];
        end
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.budget[0]       <= cwds_pkg::RST_BUDGET_CONTROL;
            r_cfg.budget[1]       <= cwds_pkg::RST_BUDGET_SENSORS;
            r_cfg.budget[2]       <= cwds_pkg::RST_BUDGET_COMMS;
            r_cfg.min_refresh_gap <= cwds_pkg::RST_MIN_REFRESH_GAP;
            r_cfg.healthy_runtime <= cwds_pkg::RST_HEALTHY_RUNTIME;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cwds_pkg::CFG_BUDGET_CONTROL:  r_cfg.budget[0] <= i_cfg_data[15:0];
                cwds_pkg::CFG_BUDGET_SENSORS:  r_cfg.budget[1] <= i_cfg_data[15:0];
                cwds_pkg::CFG_BUDGET_COMMS:    r_cfg.budget[2] <= i_cfg_data[15:0];
                cwds_pkg::CFG_MIN_REFRESH_GAP: r_cfg.min_refresh_gap <= i_cfg_data[15:0];
                cwds_pkg::CFG_HEALTHY_RUNTIME: r_cfg.healthy_runtime <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decision logic and supervisor state
    cwds_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_move),
        .i_item  (r_s1_item),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_res <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0,
                         r_res.safe_state_request,
                         r_res.limp,
                         r_res.clear_streaks,
                         r_res.starve_count,
                         r_res.refresh_count,
                         r_res.starved_mask,
                         r_res.refresh};

endmodule
